FILE: design/spn_pkg.sv
package spn_pkg;

    localparam int LEVEL_W = 16;
    localparam int DT_W    = 10;
    localparam int CFG_W   = 15;
    localparam int COEF_W  = 17;
    localparam int DIV_NW  = 34;
    localparam int DIV_QW  = 17;
    localparam int DIV_CW  = $clog2(DIV_QW);

    localparam logic [CFG_W-1:0] SPAN_RESET = 15'd1229;
    localparam logic [CFG_W-1:0] GATE_RESET = 15'd205;
    localparam logic [CFG_W-1:0] MINS_RESET = 15'd358;

    localparam logic [63:0] BASE_ATTACK  = 64'd1047844835;
    localparam logic [63:0] BASE_RELEASE = 64'd1073392355;

    localparam logic [15:0] FULL_SCALE = 16'd32768;

    localparam logic       OP_LOAD = 1'b0;
    localparam logic       OP_NORM = 1'b1;

    localparam logic [1:0] REG_SPAN = 2'd0;
    localparam logic [1:0] REG_GATE = 2'd1;
    localparam logic [1:0] REG_MINS = 2'd2;

    typedef struct packed {
        logic                      op;
        logic signed [LEVEL_W-1:0] level;
        logic                      last;
        logic [DT_W-1:0]           dt;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0] span;
        logic [CFG_W-1:0] gate;
        logic [CFG_W-1:0] mins;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] n;
        logic [DIV_NW-1:0] d;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [DIV_QW-1:0] q;
    } t_div_rsp;

endpackage

FILE: design/spectrum_peak_normalizer.sv
// Peak-tracking level normalizer. Load items (opcode 0) feed band levels of a
// frame into a sorted list of the loudest MAX_BANDS/5; a load marked last_band
// averages the loudest max(1,count/5), moves the reference toward that average
// with attack or release smoothing and returns the new reference. Normalize
// items (opcode 1) return the level mapped into the reference window as Q1.15.
// A two-item input queue separates intake from execution, and the result sits
// in an output register. A last band sums the list one entry per cycle, then
// waits on the shared radix-2 divider for the average, then multiplies and
// updates the reference; a normalize item at a window edge skips the divider,
// otherwise it waits on the same divider.
module spectrum_peak_normalizer #(
    parameter int MAX_BANDS = 64,
    parameter int DT_STEPS  = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic signed [15:0] i_level,
    input  logic               i_last_band,
    input  logic [9:0]         i_frame_dt,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_normalized,
    output logic signed [15:0] o_reference_now,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data
);
    import spn_pkg::*;

    t_item    w_item;
    logic     w_item_valid;
    logic     w_pop;
    t_cfg     r_cfg;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.span <= SPAN_RESET;
            r_cfg.gate <= GATE_RESET;
            r_cfg.mins <= MINS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SPAN: r_cfg.span <= i_cfg_data;
                REG_GATE: r_cfg.gate <= i_cfg_data;
                REG_MINS: r_cfg.mins <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    spn_front #(
        .DT_STEPS (DT_STEPS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_opcode     (i_opcode),
        .i_level      (i_level),
        .i_last_band  (i_last_band),
        .i_frame_dt   (i_frame_dt),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_pop        (w_pop)
    );

    spn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    spn_back #(
        .MAX_BANDS (MAX_BANDS),
        .DT_STEPS  (DT_STEPS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (w_item),
        .i_item_valid    (w_item_valid),
        .o_pop           (w_pop),
        .i_cfg           (r_cfg),
        .o_div           (w_div_req),
        .i_div           (w_div_rsp),
        .o_res_valid     (o_out_valid),
        .i_res_stall     (i_out_stall),
        .o_normalized    (o_normalized),
        .o_reference_now (o_reference_now)
    );

endmodule

FILE: design/spn_front.sv
module spn_front #(
    parameter int DT_STEPS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic signed [15:0]            i_level,
    input  logic                          i_last_band,
    input  logic [9:0]                    i_frame_dt,
    output spn_pkg::t_item                o_item,
    output logic                          o_item_valid,
    input  logic                          i_pop
);
    import spn_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    t_item      w_item;

    // classify: saturate the time step on entry
    always_comb begin
        w_item.op    = i_opcode;
        w_item.level = i_level;
        w_item.last  = i_last_band;
        w_item.dt    = ({1'b0, i_frame_dt} > 11'(DT_STEPS)) ? DT_W'(DT_STEPS) : i_frame_dt;
    end

    assign o_stall      = r_cnt[1];
    assign w_push       = i_valid && !r_cnt[1];
    assign o_item_valid = r_cnt != 2'd0;
    assign o_item       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

endmodule

FILE: design/spn_div.sv
module spn_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spn_pkg::t_div_req i_req,
    output spn_pkg::t_div_rsp o_rsp
);
    import spn_pkg::*;

    logic [DIV_NW-1:0] r_rem;
    logic [DIV_NW-1:0] r_dsh;
    logic [DIV_QW-1:0] r_q;
    logic [DIV_CW-1:0] r_bit;
    logic              r_busy;
    logic              w_ge;

    assign w_ge       = r_rem >= r_dsh;
    assign o_rsp.busy = r_busy;
    assign o_rsp.q    = r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.n;
            r_dsh <= i_req.d << (DIV_QW - 1);
            r_q   <= '0;
            r_bit <= DIV_CW'(DIV_QW - 1);
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[DIV_QW-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
            r_bit <= r_bit - DIV_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_bit == '0) begin
            r_busy <= 1'b0;
        end
    end

endmodule

FILE: design/spn_back.sv
module spn_back #(
    parameter int MAX_BANDS = 64,
    parameter int DT_STEPS  = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spn_pkg::t_item     i_item,
    input  logic               i_item_valid,
    output logic               o_pop,
    input  spn_pkg::t_cfg      i_cfg,
    output spn_pkg::t_div_req  o_div,
    input  spn_pkg::t_div_rsp  i_div,
    output logic               o_res_valid,
    input  logic               i_res_stall,
    output logic [15:0]        o_normalized,
    output logic signed [15:0] o_reference_now
);
    import spn_pkg::*;

    localparam int TOPN = MAX_BANDS / 5;
    localparam int CW   = $clog2(MAX_BANDS + 1);
    localparam int TW   = $clog2(TOPN + 1);
    localparam int SW   = LEVEL_W + TW + 1;
    localparam int DTW  = $clog2(DT_STEPS + 1);

    typedef logic [COEF_W-1:0] t_rom [0:DT_STEPS];

    function automatic t_rom build_rom(input logic [63:0] base, input logic inv);
        t_rom        rom;
        logic [63:0] p;
        logic [63:0] q;
        p = 64'd1 << 30;
        for (int i = 0; i <= DT_STEPS; i++) begin
            if (i > 0) begin
                p = (p * base + (64'd1 << 29)) >> 30;
            end
            q = (p + (64'd1 << 13)) >> 14;
            rom[i] = inv ? COEF_W'(64'd65536 - q) : COEF_W'(q);
        end
        return rom;
    endfunction

    localparam t_rom ATTACK_ROM  = build_rom(BASE_ATTACK, 1'b1);
    localparam t_rom RELEASE_ROM = build_rom(BASE_RELEASE, 1'b0);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_INS  = 11'b00000000010,
        S_LAST = 11'b00000000100,
        S_SUM  = 11'b00000001000,
        S_PEAK = 11'b00000010000,
        S_MUL  = 11'b00000100000,
        S_UPD  = 11'b00001000000,
        S_NH   = 11'b00010000000,
        S_NL   = 11'b00100000000,
        S_ND   = 11'b01000000000,
        S_NDIV = 11'b10000000000
    } t_state;

    t_state                    r_state;
    t_item                     r_item;
    logic [CW-1:0]             r_count;
    logic signed [LEVEL_W-1:0] r_list [TOPN];
    logic signed [LEVEL_W-1:0] r_ref;
    logic [TW-1:0]             r_top;
    logic [TW-1:0]             r_k;
    logic signed [SW-1:0]      r_sum;
    logic [COEF_W-1:0]         r_coef_a;
    logic [COEF_W-1:0]         r_coef_r;
    logic signed [LEVEL_W-1:0] r_peak;
    logic [COEF_W-1:0]         r_diff;
    logic                      r_att;
    logic [DIV_NW-1:0]         r_prod;
    logic signed [17:0]        r_high;
    logic signed [17:0]        r_low;
    logic                      r_ov;
    logic [15:0]               r_onorm;
    logic signed [15:0]        r_oref;

    logic                      w_out_free;
    logic [DTW-1:0]            w_dti;
    logic [TOPN-1:0]           w_ge;
    logic                      w_ins;
    logic                      w_sum_end;
    logic signed [SW-1:0]      n_sum;
    logic signed [DIV_NW:0]    w_pn;
    logic [DIV_NW-1:0]         w_nn;
    logic signed [17:0]        w_lv;
    logic signed [17:0]        w_span;
    logic signed [17:0]        w_fh;
    logic signed [17:0]        w_low0;
    logic signed [17:0]        w_gate;
    logic                      w_direct;
    logic [15:0]               w_direct_val;
    logic signed [LEVEL_W-1:0] w_peak;
    logic [17:0]               w_inc;
    logic [CW+7:0]             w_prod5;
    logic [TW-1:0]             w_top5;
    logic signed [LEVEL_W-1:0] n_ref;

    assign w_out_free      = !r_ov || !i_res_stall;
    assign w_dti           = DTW'(i_item.dt);
    assign o_pop           = (r_state == S_IDLE) && i_item_valid;
    assign o_res_valid     = r_ov;
    assign o_normalized    = r_onorm;
    assign o_reference_now = r_oref;

    always_comb begin
        for (int k = 0; k < TOPN; k++) begin
            w_ge[k] = (CW'(k) < r_count) && (r_list[k] >= r_item.level);
        end
    end

    always_comb begin
        w_ins     = r_count < CW'(MAX_BANDS);
        w_sum_end = r_k == (r_top - TW'(1));
        n_sum     = r_sum + SW'(r_list[0]);
        // rounded mean offset by half scale so the quotient stays positive
        w_pn      = ((DIV_NW + 1)'(n_sum) <<< 1) + ((DIV_NW + 1)'(r_top) << 16)
                  + (DIV_NW + 1)'(r_top);
        w_lv      = 18'(r_item.level);
        w_span    = r_high - r_low;
        w_nn      = (DIV_NW'(w_lv - r_low) << 16) + DIV_NW'(w_span);
        w_fh      = signed'({3'b000, i_cfg.gate} + {3'b000, i_cfg.mins});
        w_gate    = signed'({3'b000, i_cfg.gate});
        w_low0    = r_high - signed'({3'b000, i_cfg.span});
        w_peak    = signed'(i_div.q[15:0] ^ 16'h8000);
        w_inc     = 18'((r_prod + DIV_NW'(32768)) >> 16);
        n_ref     = r_att ? (r_ref + 16'(w_inc)) : (r_peak + 16'(w_inc));
        w_prod5   = (CW + 8)'(r_count) * (CW + 8)'(205);
        w_top5    = TW'(w_prod5 >> 10);

        if (w_span <= 18'sd0) begin
            w_direct     = 1'b1;
            w_direct_val = (w_lv >= r_high) ? FULL_SCALE : 16'd0;
        end else if (w_lv <= r_low) begin
            w_direct     = 1'b1;
            w_direct_val = 16'd0;
        end else if (w_lv >= r_high) begin
            w_direct     = 1'b1;
            w_direct_val = FULL_SCALE;
        end else begin
            w_direct     = 1'b0;
            w_direct_val = 16'd0;
        end

        o_div.start = ((r_state == S_SUM) && w_sum_end) || ((r_state == S_ND) && !w_direct);
        if (r_state == S_SUM) begin
            o_div.n = DIV_NW'(w_pn);
            o_div.d = DIV_NW'({r_top, 1'b0});
        end else begin
            o_div.n = w_nn;
            o_div.d = DIV_NW'({w_span, 1'b0});
        end
    end

    // sorted list of the loudest levels, shifted down while summing
    always_ff @(posedge i_clk) begin
        if (r_state == S_INS && w_ins) begin
            for (int k = 0; k < TOPN; k++) begin
                if (!w_ge[k]) begin
                    if (k == 0) begin
                        r_list[k] <= r_item.level;
                    end else if (w_ge[k-1]) begin
                        r_list[k] <= r_item.level;
                    end else begin
                        r_list[k] <= r_list[k-1];
                    end
                end
            end
        end else if (r_state == S_SUM) begin
            for (int k = 0; k < TOPN - 1; k++) begin
                r_list[k] <= r_list[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item   <= i_item;
                r_coef_a <= ATTACK_ROM[w_dti];
                r_coef_r <= RELEASE_ROM[w_dti];
            end
            S_LAST: begin
                r_top <= (w_top5 == '0) ? TW'(1) : w_top5;
                r_k   <= '0;
                r_sum <= '0;
            end
            S_SUM: begin
                r_sum <= n_sum;
                r_k   <= r_k + TW'(1);
            end
            S_PEAK: begin
                r_peak <= w_peak;
                r_att  <= w_peak > r_ref;
                r_diff <= (w_peak > r_ref) ? COEF_W'(17'(w_peak) - 17'(r_ref))
                                           : COEF_W'(17'(r_ref) - 17'(w_peak));
            end
            S_MUL: begin
                r_prod <= DIV_NW'(r_diff * (r_att ? r_coef_a : r_coef_r));
            end
            S_NH: begin
                r_high <= (18'(r_ref) > w_fh) ? 18'(r_ref) : w_fh;
            end
            S_NL: begin
                r_low <= (w_low0 < w_gate) ? w_gate : w_low0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ref   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (!i_res_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_state <= (i_item.op == OP_NORM) ? S_NH : S_INS;
                    end
                end
                S_INS: begin
                    if (w_ins) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= r_item.last ? S_LAST : S_IDLE;
                end
                S_LAST: begin
                    if (r_count != '0) begin
                        r_state <= S_SUM;
                    end else if (w_out_free) begin
                        r_ov    <= 1'b1;
                        r_onorm <= 16'd0;
                        r_oref  <= r_ref;
                        r_state <= S_IDLE;
                    end
                end
                S_SUM: begin
                    if (w_sum_end) begin
                        r_state <= S_PEAK;
                    end
                end
                S_PEAK: begin
                    if (!i_div.busy) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_out_free) begin
                        r_ref   <= n_ref;
                        r_count <= '0;
                        r_ov    <= 1'b1;
                        r_onorm <= 16'd0;
                        r_oref  <= n_ref;
                        r_state <= S_IDLE;
                    end
                end
                S_NH: begin
                    r_state <= S_NL;
                end
                S_NL: begin
                    r_state <= S_ND;
                end
                S_ND: begin
                    if (!w_direct) begin
                        r_state <= S_NDIV;
                    end else if (w_out_free) begin
                        r_ov    <= 1'b1;
                        r_onorm <= w_direct_val;
                        r_oref  <= r_ref;
                        r_state <= S_IDLE;
                    end
                end
                S_NDIV: begin
                    if (!i_div.busy && w_out_free) begin
                        r_ov    <= 1'b1;
                        r_onorm <= i_div.q[15:0];
                        r_oref  <= r_ref;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: design/spn_checker.sv
module spn_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [15:0]        o_normalized,
    input logic signed [15:0] o_reference_now
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped under stall");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_normalized) && $stable(o_reference_now))
        else $error("result changed under stall");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_normalized <= 16'd32768)
        else $error("normalized level above full scale");

endmodule

bind spectrum_peak_normalizer spn_checker u_spn_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_normalized    (o_normalized),
    .o_reference_now (o_reference_now)
);
